### hw/rtl/sbic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbic_pkg
// types and constants shared by the sorted bucket insert unit
// ----------------------------------------------------------------------------
package sbic_pkg;

  localparam int BUCKET_W = 10;
  localparam int WORD_W   = 64;
  localparam int ENTRY_W  = 4 * WORD_W;
  localparam int MOD_K_W  = 4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_COLLISION = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_FILL_RD,
    S_FILL_CHK,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT,
    S_DONE
  } state_t;

  // largest k such that n << k still fits below 2**BUCKET_W
  function automatic int mod_shift(input int n);
    int k;
    k = 0;
    for (int i = 0; i < BUCKET_W; i++) begin
      if ((n << (i + 1)) < (1 << BUCKET_W)) begin
        k = i + 1;
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sbic_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbic_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module sbic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/sorted_bucket_insert_with_collision_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_bucket_insert_with_collision_unit
// bucketed table with sorted insert, duplicate and collision detection
// ----------------------------------------------------------------------------
// After reset the unit sweeps the per-bucket fill memory, one bucket per
// cycle, and in_ready stays low until the sweep is done. Each transaction
// is then handled alone, and in_ready stays low until its result is loaded
// into the output register. The bucket index is reduced modulo NUM_BUCKETS
// by a shift-and-subtract unit, which is skipped when NUM_BUCKETS covers
// the 10-bit index. The fill count is then read, and the bucket is
// binary-searched with 128-bit equal and less-than key compares, each
// probe reading the middle entry and then comparing it. An insert moves
// the later entries up through the entry memory, one entry per cycle, and
// then writes the new entry. The result is loaded into the output register
// once the previous result no longer waits for out_ready.
module sorted_bucket_insert_with_collision_unit
  import sbic_pkg::*;
#(
  parameter int NUM_BUCKETS  = 1024,
  parameter int BUCKET_SLOTS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [BUCKET_W-1:0] bucket,
  input  wire logic [WORD_W-1:0]   key_low,
  input  wire logic [WORD_W-1:0]   key_high,
  input  wire logic [WORD_W-1:0]   dist_low,
  input  wire logic [WORD_W-1:0]   dist_high,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               status,
  output logic [WORD_W-1:0]        match_dist_low,
  output logic [WORD_W-1:0]        match_dist_high
);

  localparam int BW       = $clog2(NUM_BUCKETS);
  localparam int SLOT_W   = $clog2(BUCKET_SLOTS);
  localparam int DEPTH    = NUM_BUCKETS * BUCKET_SLOTS;
  localparam int AW       = $clog2(DEPTH);
  localparam bit NEED_MOD = NUM_BUCKETS < (1 << BUCKET_W);
  localparam int MOD_SH   = mod_shift(NUM_BUCKETS);
  localparam logic [SLOT_W-1:0] FULL    = SLOT_W'(BUCKET_SLOTS - 1);
  localparam logic [BW-1:0]     NB_LAST = BW'(NUM_BUCKETS - 1);

  state_t state, state_next;

  logic [BW-1:0]       clr_idx;
  logic [BUCKET_W-1:0] rem;
  logic [MOD_K_W-1:0]  mod_k;
  logic [WORD_W-1:0]   req_key_low, req_key_high, req_dist_low, req_dist_high;
  logic [AW-1:0]       base;
  logic [SLOT_W-1:0]   fill, lo, hiex, mid, sh_i, sh_dst;
  logic                sh_pend;
  status_t             res_status;
  logic [WORD_W-1:0]   res_dist_low, res_dist_high;

  logic [BW-1:0]       bidx;
  logic [31:0]         mod_dv;
  logic                mod_ge;
  logic [SLOT_W:0]     mid_sum;
  logic [SLOT_W-1:0]   mid_calc, sh_prev;
  logic                key_eq, key_lt, dist_eq, sh_last, out_load;

  logic                fill_we;
  logic [BW-1:0]       fill_waddr;
  logic [SLOT_W-1:0]   fill_wdata, fill_rdata;
  logic                ent_we;
  logic [AW-1:0]       ent_waddr, ent_raddr;
  logic [ENTRY_W-1:0]  ent_wdata, ent_rdata;

  assign bidx     = BW'(rem);
  assign mod_dv   = 32'(NUM_BUCKETS) << mod_k;
  assign mod_ge   = 32'(rem) >= mod_dv;
  assign mid_sum  = {1'b0, lo} + {1'b0, hiex} - {{SLOT_W{1'b0}}, 1'b1};
  assign mid_calc = mid_sum[SLOT_W:1];
  assign sh_prev  = sh_i - SLOT_W'(1);
  assign key_eq   = {ent_rdata[2*WORD_W-1:WORD_W], ent_rdata[WORD_W-1:0]} ==
                    {req_key_high, req_key_low};
  assign key_lt   = {req_key_high, req_key_low} <
                    {ent_rdata[2*WORD_W-1:WORD_W], ent_rdata[WORD_W-1:0]};
  assign dist_eq  = {ent_rdata[4*WORD_W-1:3*WORD_W], ent_rdata[3*WORD_W-1:2*WORD_W]} ==
                    {req_dist_high, req_dist_low};
  assign sh_last  = !sh_pend && !(sh_i > lo);
  assign out_load = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == NB_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = NEED_MOD ? S_MOD : S_FILL_RD;
      end
      S_MOD: begin
        if (mod_k == '0) state_next = S_FILL_RD;
      end
      S_FILL_RD: state_next = S_FILL_CHK;
      S_FILL_CHK: begin
        state_next = (fill_rdata >= FULL) ? S_DONE : S_SRCH_RD;
      end
      S_SRCH_RD: begin
        state_next = (lo < hiex) ? S_SRCH_CMP : S_SHIFT;
      end
      S_SRCH_CMP: begin
        state_next = key_eq ? S_DONE : S_SRCH_RD;
      end
      S_SHIFT: begin
        if (sh_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // memory control and handshake
  always_comb begin
    in_ready   = 1'b0;
    fill_we    = 1'b0;
    fill_waddr = bidx;
    fill_wdata = fill + SLOT_W'(1);
    ent_we     = 1'b0;
    ent_waddr  = base + AW'(lo);
    ent_wdata  = {req_dist_high, req_dist_low, req_key_high, req_key_low};
    ent_raddr  = base + AW'(mid_calc);
    unique case (state)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_idx;
        fill_wdata = '0;
      end
      S_IDLE: in_ready = 1'b1;
      S_SHIFT: begin
        ent_raddr = base + AW'(sh_prev);
        if (sh_pend) begin
          ent_we    = 1'b1;
          ent_waddr = base + AW'(sh_dst);
          ent_wdata = ent_rdata;
        end else if (sh_last) begin
          ent_we  = 1'b1;
          fill_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr_idx <= clr_idx + BW'(1);
        S_IDLE: begin
          if (in_valid) begin
            rem           <= bucket;
            mod_k         <= MOD_K_W'(MOD_SH);
            req_key_low   <= key_low;
            req_key_high  <= key_high;
            req_dist_low  <= dist_low;
            req_dist_high <= dist_high;
          end
        end
        S_MOD: begin
          if (mod_ge) rem <= rem - BUCKET_W'(mod_dv);
          mod_k <= mod_k - MOD_K_W'(1);
        end
        S_FILL_RD: base <= AW'(bidx) * AW'(BUCKET_SLOTS);
        S_FILL_CHK: begin
          fill          <= fill_rdata;
          lo            <= '0;
          hiex          <= fill_rdata;
          res_status    <= (fill_rdata >= FULL) ? ST_OVERFLOW : ST_OK;
          res_dist_low  <= '0;
          res_dist_high <= '0;
        end
        S_SRCH_RD: begin
          mid     <= mid_calc;
          sh_i    <= fill;
          sh_pend <= 1'b0;
        end
        S_SRCH_CMP: begin
          if (key_eq) begin
            if (dist_eq) begin
              res_status <= ST_DUPLICATE;
            end else begin
              res_status    <= ST_COLLISION;
              res_dist_low  <= ent_rdata[3*WORD_W-1:2*WORD_W];
              res_dist_high <= ent_rdata[4*WORD_W-1:3*WORD_W];
            end
          end else if (key_lt) begin
            hiex <= mid;
          end else begin
            lo <= mid + SLOT_W'(1);
          end
        end
        S_SHIFT: begin
          if (sh_i > lo) begin
            sh_dst  <= sh_i;
            sh_i    <= sh_prev;
            sh_pend <= 1'b1;
          end else begin
            sh_pend <= 1'b0;
          end
        end
        S_DONE: begin
          if (out_load) begin
            status          <= res_status;
            match_dist_low  <= res_dist_low;
            match_dist_high <= res_dist_high;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-bucket fill counts
  sbic_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(NUM_BUCKETS)
  ) u_fill_ram (
    .clk  (clk),
    .we   (fill_we),
    .waddr(fill_waddr),
    .wdata(fill_wdata),
    .raddr(bidx),
    .rdata(fill_rdata)
  );

  // entries: dist high, dist low, key high, key low
  sbic_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

endmodule
`default_nettype wire
